>>> sv/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, word types and constants for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // Width of every input and output component.
    localparam int DATA_W = 32;
    // Width of a scaled rotation matrix entry: two 64-bit products, doubled.
    localparam int MAT_W  = 66;
    // Width of the squared norm: the sum of four squares.
    localparam int NORM_W = 65;
    // Width of a row accumulator and of the rounding numerator.
    localparam int ACC_W  = 100;
    // Low and high slices of a matrix entry for the split multiply.
    localparam int LO_W   = 33;
    localparam int HI_W   = MAT_W - LO_W;
    // Quotient bits kept by the divider; the rounded quotient stays below 2**33.
    localparam int QUO_W  = 34;
    // Partial remainder width; it stays below the divisor of MAT_W bits.
    localparam int REM_W  = MAT_W;
    // One divider step per pipeline stage.
    localparam int DIV_STEPS = QUO_W;

    // Largest magnitudes that still fit the signed 32-bit output.
    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(34'h0_7FFF_FFFF);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(34'h0_8000_0000);

    // Input word: quaternion and the vector to rotate.
    typedef struct packed {
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } in_word_t;

    // Output word: rotated vector and the clipping flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     saturated;
    } out_word_t;

    // Scaled rotation matrix (row major), squared norm and the vector.
    typedef struct packed {
        logic [8:0][MAT_W-1:0]  m;
        logic [NORM_W-1:0]      norm;
        logic [2:0][DATA_W-1:0] v;
    } mat_word_t;

    // Divider state for the three rows, carried from stage to stage.
    typedef struct packed {
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] num;
        logic [2:0][QUO_W-1:0] quot;
        logic [2:0]            neg;
        logic [MAT_W-1:0]      den;
        logic                  zero;
    } div_word_t;

endpackage

>>> sv/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix
// Two stages: the ten quaternion products, then the scaled rotation matrix
// and the squared norm.
// ----------------------------------------------------------------------------
module qvr_matrix (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qvr_pkg::in_word_t   in_data,
    output logic                out_valid,
    output qvr_pkg::mat_word_t  out_data
);

    logic signed [63:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [63:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [2:0][qvr_pkg::DATA_W-1:0] vec_reg;
    logic                            prod_valid_reg;
    qvr_pkg::mat_word_t              mat_next;
    qvr_pkg::mat_word_t              mat_reg;
    logic                            mat_valid_reg;

    function automatic logic signed [qvr_pkg::MAT_W-1:0] sx(input logic signed [63:0] p);
        return qvr_pkg::MAT_W'(p);
    endfunction

    // Valid bits advance with the pipeline enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mat_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            mat_valid_reg  <= prod_valid_reg;
        end
    end

    // Stage one: all pairwise products of the quaternion components.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= in_data.quat_x * in_data.quat_x;
            yy_reg  <= in_data.quat_y * in_data.quat_y;
            zz_reg  <= in_data.quat_z * in_data.quat_z;
            ww_reg  <= in_data.quat_w * in_data.quat_w;
            xy_reg  <= in_data.quat_x * in_data.quat_y;
            xz_reg  <= in_data.quat_x * in_data.quat_z;
            yz_reg  <= in_data.quat_y * in_data.quat_z;
            wx_reg  <= in_data.quat_w * in_data.quat_x;
            wy_reg  <= in_data.quat_w * in_data.quat_y;
            wz_reg  <= in_data.quat_w * in_data.quat_z;
            vec_reg <= {in_data.vec_z, in_data.vec_y, in_data.vec_x};
        end
    end

    // Stage two: matrix entries scaled by the squared norm.
    always_comb
    begin
        mat_next.m[0] = sx(ww_reg) + sx(xx_reg) - sx(yy_reg) - sx(zz_reg);
        mat_next.m[1] = (sx(xy_reg) - sx(wz_reg)) <<< 1;
        mat_next.m[2] = (sx(xz_reg) + sx(wy_reg)) <<< 1;
        mat_next.m[3] = (sx(xy_reg) + sx(wz_reg)) <<< 1;
        mat_next.m[4] = sx(ww_reg) - sx(xx_reg) + sx(yy_reg) - sx(zz_reg);
        mat_next.m[5] = (sx(yz_reg) - sx(wx_reg)) <<< 1;
        mat_next.m[6] = (sx(xz_reg) - sx(wy_reg)) <<< 1;
        mat_next.m[7] = (sx(yz_reg) + sx(wx_reg)) <<< 1;
        mat_next.m[8] = sx(ww_reg) - sx(xx_reg) - sx(yy_reg) + sx(zz_reg);
        // Squares are never negative, so they add as unsigned values.
        mat_next.norm = {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg} + {1'b0, ww_reg};
        mat_next.v    = vec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg <= mat_next;
        end
    end

    assign out_valid = mat_valid_reg;
    assign out_data  = mat_reg;

endmodule

>>> sv/qvr_accum.sv
// ----------------------------------------------------------------------------
// qvr_accum
// Matrix times vector in four stages: split partial products, column terms,
// row sums, then the rounding numerator and divisor for the divider.
// ----------------------------------------------------------------------------
module qvr_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qvr_pkg::mat_word_t  in_data,
    output logic                out_valid,
    output qvr_pkg::div_word_t  out_data
);

    logic signed [qvr_pkg::MAT_W-1:0] lo_reg [9];
    logic signed [qvr_pkg::MAT_W-2:0] hi_reg [9];
    logic signed [qvr_pkg::ACC_W-1:0] col_reg [9];
    logic signed [qvr_pkg::ACC_W-1:0] acc_reg [3];
    logic [qvr_pkg::NORM_W-1:0]       norm_c_reg, norm_d_reg, norm_e_reg;
    logic [3:0]                       valid_reg;
    qvr_pkg::div_word_t               div_next;
    qvr_pkg::div_word_t               div_reg;

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Stage one: each entry times its vector component, low and high slices.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    lo_reg[r*3+c] <= $signed({1'b0, in_data.m[r*3+c][qvr_pkg::LO_W-1:0]})
                                     * $signed(in_data.v[c]);
                    hi_reg[r*3+c] <= $signed(in_data.m[r*3+c][qvr_pkg::MAT_W-1:qvr_pkg::LO_W])
                                     * $signed(in_data.v[c]);
                end
            end
            norm_c_reg <= in_data.norm;
        end
    end

    // Stage two: join the two slices of each term.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                col_reg[i] <= (qvr_pkg::ACC_W'(hi_reg[i]) <<< qvr_pkg::LO_W)
                              + qvr_pkg::ACC_W'(lo_reg[i]);
            end
            norm_d_reg <= norm_c_reg;
        end
    end

    // Stage three: row sums, exact.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc_reg[r] <= col_reg[r*3] + col_reg[r*3+1] + col_reg[r*3+2];
            end
            norm_e_reg <= norm_d_reg;
        end
    end

    // Stage four: round half away from zero as (2|acc| + n) / (2n).
    always_comb
    begin
        logic [qvr_pkg::ACC_W-1:0] mag;
        logic [qvr_pkg::ACC_W-1:0] numer;
        for (int r = 0; r < 3; r++)
        begin
            mag   = acc_reg[r][qvr_pkg::ACC_W-1] ? qvr_pkg::ACC_W'(-acc_reg[r])
                                                 : qvr_pkg::ACC_W'(acc_reg[r]);
            numer = {mag[qvr_pkg::ACC_W-2:0], 1'b0} + qvr_pkg::ACC_W'(norm_e_reg);
            div_next.rem[r]  = numer[qvr_pkg::ACC_W-1:qvr_pkg::QUO_W];
            div_next.num[r]  = numer[qvr_pkg::QUO_W-1:0];
            div_next.quot[r] = '0;
            div_next.neg[r]  = acc_reg[r][qvr_pkg::ACC_W-1];
        end
        div_next.den  = {norm_e_reg, 1'b0};
        div_next.zero = (norm_e_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = div_reg;

endmodule

>>> sv/qvr_div_step.sv
// ----------------------------------------------------------------------------
// qvr_div_step
// One registered restoring-division step for all three rows.
// ----------------------------------------------------------------------------
module qvr_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  qvr_pkg::div_word_t  in_data,
    output logic                out_valid,
    output qvr_pkg::div_word_t  out_data
);

    qvr_pkg::div_word_t step_next;
    qvr_pkg::div_word_t step_reg;
    logic               valid_reg;

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb
    begin
        logic [qvr_pkg::REM_W:0] trial;
        logic                    fits;
        step_next = in_data;
        for (int r = 0; r < 3; r++)
        begin
            trial = {in_data.rem[r], in_data.num[r][qvr_pkg::QUO_W-1]};
            fits  = (trial >= {1'b0, in_data.den});
            step_next.rem[r]  = fits ? qvr_pkg::REM_W'(trial - {1'b0, in_data.den})
                                     : trial[qvr_pkg::REM_W-1:0];
            step_next.num[r]  = {in_data.num[r][qvr_pkg::QUO_W-2:0], 1'b0};
            step_next.quot[r] = {in_data.quot[r][qvr_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = step_reg;

endmodule

>>> sv/quaternion_vector_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates a Q16.16 vector by a quaternion, q * v * q^-1, with saturation.
// ----------------------------------------------------------------------------
// Usage:
// One input word carries the quaternion and the vector; one output word
// carries the rotated vector and a flag that is set when any component was
// clipped to the signed 32-bit range. A zero quaternion gives a zero vector.
// Both channels move a word at a rising edge where valid is high and stall
// is low.
// The pipeline holds two stages for the quaternion products and the
// matrix, four for the matrix-vector product and rounding setup, 34 stages
// of the restoring divider (one quotient bit per stage) and the output
// register. Throughput is one word per clock while the pipeline is not frozen.
// The whole pipeline advances together. When the output register holds a
// word and out_stall is high, the pipeline freezes and in_stall is raised;
// nothing is dropped or repeated. While the output register is empty, words
// keep entering even with out_stall high.
// Reset clears every valid bit; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qvr_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output qvr_pkg::out_word_t  out_data
);

    logic                en;
    logic                mat_valid;
    qvr_pkg::mat_word_t  mat_data;
    logic                div_valid [qvr_pkg::DIV_STEPS+1];
    qvr_pkg::div_word_t  div_data  [qvr_pkg::DIV_STEPS+1];
    qvr_pkg::out_word_t  out_next;
    qvr_pkg::out_word_t  out_data_reg;
    logic                out_valid_reg;

    // The pipeline moves unless a finished word is held by the receiver.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    qvr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (mat_valid),
        .out_data  (mat_data)
    );

    qvr_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat_valid),
        .in_data   (mat_data),
        .out_valid (div_valid[0]),
        .out_data  (div_data[0])
    );

    // Divider chain, one quotient bit per stage.
    for (genvar s = 0; s < qvr_pkg::DIV_STEPS; s++)
    begin : g_div
        qvr_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_valid[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    // Clip each quotient, apply the sign and collect the clipping flag.
    always_comb
    begin
        logic [qvr_pkg::QUO_W-1:0]  limit;
        logic [qvr_pkg::QUO_W-1:0]  clip;
        logic [qvr_pkg::DATA_W-1:0] mag;
        logic [qvr_pkg::DATA_W-1:0] res [3];
        logic                       sat;
        sat = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            limit = div_data[qvr_pkg::DIV_STEPS].neg[r] ? qvr_pkg::NEG_LIMIT
                                                        : qvr_pkg::POS_LIMIT;
            clip  = div_data[qvr_pkg::DIV_STEPS].quot[r];
            if (clip > limit)
            begin
                clip = limit;
                sat  = 1'b1;
            end
            mag    = clip[qvr_pkg::DATA_W-1:0];
            res[r] = div_data[qvr_pkg::DIV_STEPS].neg[r] ? (~mag + 1'b1) : mag;
        end
        if (div_data[qvr_pkg::DIV_STEPS].zero)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.out_x     = res[0];
            out_next.out_y     = res[1];
            out_next.out_z     = res[2];
            out_next.saturated = sat;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid[qvr_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> sv/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qvr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input qvr_pkg::in_word_t   in_data,
    input logic                out_valid,
    input logic                out_stall,
    input qvr_pkg::out_word_t  out_data
);

    // A held output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // A held input word stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input word changed while stalled");

    // The input is only held off while a finished word is held.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output word");

    // A clipped word shows at least one component at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.out_x == 32'sh7FFF_FFFF || out_data.out_x == -32'sh8000_0000 ||
            out_data.out_y == 32'sh7FFF_FFFF || out_data.out_y == -32'sh8000_0000 ||
            out_data.out_z == 32'sh7FFF_FFFF || out_data.out_z == -32'sh8000_0000)
        else $error("saturated flag without a clipped component");

    // Nothing is offered while reset is applied.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
